@@ rtl/core/hscf_pkg.sv @@
// Package for the sphere contact force block: widths, payload words, queue job,
// configuration snapshot, back-end states and the force packing function.
// No dependencies.
package hscf_pkg;

  localparam int COORD_W = 24;
  localparam int MAG_W   = COORD_W + 1;
  localparam int RAD_W   = 23;
  localparam int CMP_W   = (MAG_W > RAD_W) ? MAG_W : RAD_W;
  localparam int SQ_W    = 2 * RAD_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int STF_W   = 16;
  localparam int KP_W    = STF_W + RAD_W;
  localparam int KP_LO_W = 20;
  localparam int KP_HI_W = KP_W - KP_LO_W;
  localparam int PRD_W   = KP_W + RAD_W;
  localparam int NUM_W   = PRD_W - 8;
  localparam int OUT_W   = 24;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_Z   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RADIUS     = 3'd3;
  localparam logic [IDX_W-1:0] REG_STIFFNESS  = 3'd4;
  localparam logic [IDX_W-1:0] REG_FORCE_MODE = 3'd5;

  localparam logic MODE_REPEL = 1'b0;
  localparam logic MODE_PULL  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic                    inside_res;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RAD_W-1:0]          radius;
    logic [STF_W-1:0]          stiffness;
    logic                      force_mode;
  } cfg_t;

  typedef struct packed {
    logic [2:0][RAD_W-1:0] mag;
    logic [2:0]            neg;
    logic                  in_sphere;
    logic [SUM_W-1:0]      sum;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_MUL1, ST_MUL2, ST_MUL3, ST_DIV, ST_DONE
  } st_t;

  // Apply sign to a quotient magnitude and saturate to the output range.
  function automatic logic signed [OUT_W-1:0] pack_force(
    input logic [OUT_W-1:0] q,
    input logic             sat,
    input logic             neg
  );
    logic signed [OUT_W-1:0] r;
    if (neg) begin
      if (sat || (q[OUT_W-1] && (q[OUT_W-2:0] != '0))) begin
        r = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        r = -$signed(q);
      end
    end else begin
      if (sat || q[OUT_W-1]) begin
        r = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        r = $signed(q);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/hscf_front.sv @@
// Front end: take position words, form offsets, magnitudes and squared distance,
// classify inside/outside and hand a job to the queue. Depends on hscf_pkg.
module hscf_front (
  input  logic              clk,
  input  logic              rst,
  input  hscf_pkg::cfg_t    cfg,
  input  logic              push,
  output logic              full,
  input  hscf_pkg::in_t     sample,
  output logic              job_push,
  input  logic              job_full,
  output hscf_pkg::job_t    job
);

  logic                                  v1;
  logic [2:0][hscf_pkg::MAG_W-1:0]       a1;
  logic [2:0]                            n1;
  logic                                  v2;
  logic [2:0][hscf_pkg::SQ_W-1:0]        sq2;
  logic [hscf_pkg::SQ_W-1:0]             rsq2;
  logic [2:0][hscf_pkg::RAD_W-1:0]       a2;
  logic [2:0]                            n2;
  logic                                  in2;
  logic                                  adv;
  logic [2:0][hscf_pkg::MAG_W-1:0]       a_c;
  logic [2:0]                            n_c;
  logic [2:0]                            far_c;
  logic signed [hscf_pkg::MAG_W-1:0]     d_c [3];
  logic [hscf_pkg::SUM_W-1:0]            sum_c;

  assign adv  = !v2 || !job_full;
  assign full = !adv;

  always_comb begin
    d_c[0] = hscf_pkg::MAG_W'(sample.pos_x) - hscf_pkg::MAG_W'(cfg.center_x);
    d_c[1] = hscf_pkg::MAG_W'(sample.pos_y) - hscf_pkg::MAG_W'(cfg.center_y);
    d_c[2] = hscf_pkg::MAG_W'(sample.pos_z) - hscf_pkg::MAG_W'(cfg.center_z);
    for (int i = 0; i < 3; i++) begin
      n_c[i] = d_c[i][hscf_pkg::MAG_W-1];
      a_c[i] = n_c[i] ? hscf_pkg::MAG_W'(-d_c[i]) : hscf_pkg::MAG_W'(d_c[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      far_c[i] = hscf_pkg::CMP_W'(a1[i]) >= hscf_pkg::CMP_W'(cfg.radius);
    end
    sum_c = hscf_pkg::SUM_W'(sq2[0]) + hscf_pkg::SUM_W'(sq2[1]) + hscf_pkg::SUM_W'(sq2[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
    end
  end

  // Sign-extended offsets above: MAG_W casts of signed values keep the sign.
  always_ff @(posedge clk) begin
    if (adv) begin
      a1   <= a_c;
      n1   <= n_c;
      in2  <= (far_c == 3'b000);
      n2   <= n1;
      rsq2 <= hscf_pkg::SQ_W'(cfg.radius) * hscf_pkg::SQ_W'(cfg.radius);
      for (int i = 0; i < 3; i++) begin
        a2[i]  <= hscf_pkg::RAD_W'(a1[i]);
        sq2[i] <= hscf_pkg::SQ_W'(hscf_pkg::RAD_W'(a1[i])) *
                  hscf_pkg::SQ_W'(hscf_pkg::RAD_W'(a1[i]));
      end
    end
  end

  assign job_push      = v2 && !job_full;
  assign job.mag       = a2;
  assign job.neg       = n2;
  assign job.in_sphere = in2 && (sum_c < hscf_pkg::SUM_W'(rsq2));
  assign job.sum       = sum_c;

endmodule

@@ rtl/core/hscf_queue.sv @@
// Two-entry job queue between front and back ends.
// Depends on hscf_pkg for the job word.
module hscf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hscf_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output hscf_pkg::job_t rdata,
  output logic           empty
);

  hscf_pkg::job_t slot [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;

  assign full  = cnt[1];
  assign empty = (cnt == 2'd0);
  assign rdata = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= wdata;
  end

endmodule

@@ rtl/core/hscf_back.sv @@
// Back end: bit-serial square root, split multiply, three restoring dividers,
// saturating pack and the result register. Depends on hscf_pkg.
module hscf_back (
  input  logic           clk,
  input  logic           rst,
  input  hscf_pkg::cfg_t cfg,
  input  logic           job_empty,
  input  hscf_pkg::job_t job_in,
  output logic           job_pop,
  output logic           empty,
  input  logic           pop,
  output hscf_pkg::out_t result
);

  hscf_pkg::st_t                         state, state_next;
  hscf_pkg::job_t                        job;
  logic [hscf_pkg::SUM_W-1:0]            rn, rres, rbit;
  logic [hscf_pkg::CNT_W-1:0]            cnt;
  logic [hscf_pkg::RAD_W-1:0]            root;
  logic                                  zero;
  logic [hscf_pkg::KP_W-1:0]             kp;
  logic [2:0][hscf_pkg::KP_HI_W+hscf_pkg::RAD_W-1:0] ph;
  logic [2:0][hscf_pkg::KP_LO_W+hscf_pkg::RAD_W-1:0] pl;
  logic [2:0][hscf_pkg::OUT_W-1:0]       rem, nlo, quo;
  logic [2:0]                            sat;
  logic                                  out_valid;
  logic [hscf_pkg::SUM_W-1:0]            trial;
  logic                                  last_step;
  logic                                  out_free;
  logic [2:0][hscf_pkg::NUM_W-1:0]       num;
  logic [2:0][hscf_pkg::OUT_W-1:0]       t;

  assign trial     = rres + rbit;
  assign last_step = (cnt == hscf_pkg::CNT_W'(hscf_pkg::SQRT_STEPS - 1));
  assign out_free  = !out_valid || pop;
  assign empty     = !out_valid;
  assign job_pop   = (state == hscf_pkg::ST_IDLE) && !job_empty;

  always_ff @(posedge clk) begin
    if (rst) state <= hscf_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      hscf_pkg::ST_IDLE: if (!job_empty) state_next = hscf_pkg::ST_SQRT;
      hscf_pkg::ST_SQRT: if (last_step)  state_next = hscf_pkg::ST_MUL1;
      hscf_pkg::ST_MUL1: begin
        if (!job.in_sphere || rres == '0) state_next = hscf_pkg::ST_DONE;
        else                              state_next = hscf_pkg::ST_MUL2;
      end
      hscf_pkg::ST_MUL2: state_next = hscf_pkg::ST_MUL3;
      hscf_pkg::ST_MUL3: state_next = hscf_pkg::ST_DIV;
      hscf_pkg::ST_DIV:  if (cnt == hscf_pkg::CNT_W'(hscf_pkg::OUT_W - 1)) begin
        state_next = hscf_pkg::ST_DONE;
      end
      hscf_pkg::ST_DONE: if (out_free) state_next = hscf_pkg::ST_IDLE;
      default:           state_next = hscf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg.force_mode == hscf_pkg::MODE_PULL) begin
        num[i] = hscf_pkg::NUM_W'({job.mag[i], 8'd0});
      end else begin
        num[i] = hscf_pkg::NUM_W'(((hscf_pkg::PRD_W'(ph[i]) << hscf_pkg::KP_LO_W)
                                   + hscf_pkg::PRD_W'(pl[i])) >> 8);
      end
      t[i] = {rem[i][hscf_pkg::OUT_W-2:0], nlo[i][hscf_pkg::OUT_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      hscf_pkg::ST_IDLE: begin
        job  <= job_in;
        rn   <= job_in.sum;
        rres <= '0;
        rbit <= hscf_pkg::SUM_W'(1) << (hscf_pkg::SUM_W - 2);
        cnt  <= '0;
      end
      hscf_pkg::ST_SQRT: begin
        if (rn >= trial) begin
          rn   <= rn - trial;
          rres <= (rres >> 1) + rbit;
        end else begin
          rres <= rres >> 1;
        end
        rbit <= rbit >> 2;
        cnt  <= cnt + hscf_pkg::CNT_W'(1);
      end
      hscf_pkg::ST_MUL1: begin
        root <= hscf_pkg::RAD_W'(rres);
        zero <= !job.in_sphere || (rres == '0);
        kp   <= hscf_pkg::KP_W'(cfg.stiffness) *
                hscf_pkg::KP_W'(cfg.radius - hscf_pkg::RAD_W'(rres));
      end
      hscf_pkg::ST_MUL2: begin
        for (int i = 0; i < 3; i++) begin
          ph[i] <= kp[hscf_pkg::KP_W-1:hscf_pkg::KP_LO_W] * job.mag[i];
          pl[i] <= kp[hscf_pkg::KP_LO_W-1:0] * job.mag[i];
        end
      end
      hscf_pkg::ST_MUL3: begin
        cnt <= '0;
        for (int i = 0; i < 3; i++) begin
          sat[i] <= num[i][hscf_pkg::NUM_W-1:hscf_pkg::OUT_W] >=
                    (hscf_pkg::NUM_W-hscf_pkg::OUT_W)'(root);
          rem[i] <= hscf_pkg::OUT_W'(num[i][hscf_pkg::NUM_W-1:hscf_pkg::OUT_W]);
          nlo[i] <= num[i][hscf_pkg::OUT_W-1:0];
          quo[i] <= '0;
        end
      end
      hscf_pkg::ST_DIV: begin
        cnt <= cnt + hscf_pkg::CNT_W'(1);
        for (int i = 0; i < 3; i++) begin
          nlo[i] <= nlo[i] << 1;
          if (t[i] >= hscf_pkg::OUT_W'(root)) begin
            rem[i] <= t[i] - hscf_pkg::OUT_W'(root);
            quo[i] <= {quo[i][hscf_pkg::OUT_W-2:0], 1'b1};
          end else begin
            rem[i] <= t[i];
            quo[i] <= {quo[i][hscf_pkg::OUT_W-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // Result register: load on the finishing cycle, drop on pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hscf_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hscf_pkg::ST_DONE && out_free) begin
      result.inside_res <= job.in_sphere;
      if (zero) begin
        result.force_x <= '0;
        result.force_y <= '0;
        result.force_z <= '0;
      end else begin
        result.force_x <= hscf_pkg::pack_force(quo[0], sat[0],
                            job.neg[0] ^ (cfg.force_mode == hscf_pkg::MODE_PULL));
        result.force_y <= hscf_pkg::pack_force(quo[1], sat[1],
                            job.neg[1] ^ (cfg.force_mode == hscf_pkg::MODE_PULL));
        result.force_z <= hscf_pkg::pack_force(quo[2], sat[2],
                            job.neg[2] ^ (cfg.force_mode == hscf_pkg::MODE_PULL));
      end
    end
  end

endmodule

@@ rtl/core/haptic_sphere_contact_force.sv @@
// Top level of the sphere contact force block: configuration registers,
// front end, job queue and back end. Depends on hscf_pkg and the hscf_* modules.
//
//   channel   handshake        word
//   sample    push / full      pos_x, pos_y, pos_z
//   result    empty / pop      force_x, force_y, force_z, inside_res
//   config    wr_en            wr_idx selects register, wr_data value
//
// The front end takes a sample word every cycle while it can advance and
// classifies it in two registered stages. The back end works one job at a
// time and sets the rate: a load, 24 square-root steps, three multiply states,
// 24 divider steps for all axes in parallel and a finish; a word outside skips
// the divide. Reset is synchronous, clears all handshake state and restores
// the configuration defaults. A held result stalls the back end only at its
// finish; the queue and two front stages absorb four words before full rises.
module haptic_sphere_contact_force (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  hscf_pkg::in_t                 sample,
  output logic                          empty,
  input  logic                          pop,
  output hscf_pkg::out_t                result,
  input  logic                          wr_en,
  input  logic [hscf_pkg::IDX_W-1:0]    wr_idx,
  input  logic [hscf_pkg::COORD_W-1:0]  wr_data
);

  hscf_pkg::cfg_t cfg;
  hscf_pkg::job_t job_w, job_r;
  logic           job_push, job_full, job_pop, job_empty;

  // Register file: ignore writes to indexes beyond the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x   <= '0;
      cfg.center_y   <= '0;
      cfg.center_z   <= '0;
      cfg.radius     <= hscf_pkg::RAD_W'(10240);
      cfg.stiffness  <= hscf_pkg::STF_W'(256);
      cfg.force_mode <= hscf_pkg::MODE_REPEL;
    end else if (wr_en) begin
      case (wr_idx)
        hscf_pkg::REG_CENTER_X:   cfg.center_x   <= wr_data;
        hscf_pkg::REG_CENTER_Y:   cfg.center_y   <= wr_data;
        hscf_pkg::REG_CENTER_Z:   cfg.center_z   <= wr_data;
        hscf_pkg::REG_RADIUS:     cfg.radius     <= hscf_pkg::RAD_W'(wr_data);
        hscf_pkg::REG_STIFFNESS:  cfg.stiffness  <= hscf_pkg::STF_W'(wr_data);
        hscf_pkg::REG_FORCE_MODE: cfg.force_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Front: classify each sample and forward it as a job.
  hscf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .sample   (sample),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job_w)
  );

  // Queue: decouple the fast front from the iterative back.
  hscf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_w),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_r),
    .empty (job_empty)
  );

  // Back: distance, penalty force and the result register.
  hscf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job_in    (job_r),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(job_push && job_full))
    else $error("job queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(job_pop && job_empty))
    else $error("job queue popped while empty");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.inside_res) |->
      (result.force_x == '0 && result.force_y == '0 && result.force_z == '0))
    else $error("nonzero force outside the sphere");
`endif

endmodule
